// ===== rtl/plf_pkg.sv =====
// Playfair cipher package: sizes, letter codes, digraph and result types,
// key square search. Used by every module of the playfair_cipher block.
package plf_pkg;

  localparam int GRID_SIZE = 5;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int LETTER_W  = 5;
  localparam int POS_W     = $clog2(GRID_SIZE);
  localparam int CELL_W    = $clog2(CELLS);
  localparam int HALF_W    = 60;
  localparam int CFG_IDX_W = 2;

  localparam logic [LETTER_W-1:0] LET_I = LETTER_W'(8);
  localparam logic [LETTER_W-1:0] LET_J = LETTER_W'(9);
  localparam logic [LETTER_W-1:0] LET_Q = LETTER_W'(16);
  localparam logic [LETTER_W-1:0] LET_X = LETTER_W'(23);
  localparam logic [LETTER_W-1:0] LET_Z = LETTER_W'(25);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECRYPT = 2'd0,
    CFG_LOW     = 2'd1,
    CFG_MID     = 2'd2,
    CFG_LAST    = 2'd3
  } plf_cfg_idx_t;

  typedef logic [CELLS-1:0][LETTER_W-1:0] plf_square_t;

  typedef struct packed {
    logic [LETTER_W-1:0] a;
    logic [LETTER_W-1:0] b;
    logic                last;
  } plf_digraph_t;

  typedef struct packed {
    logic [LETTER_W-1:0] l0;
    logic [LETTER_W-1:0] l1;
    logic                last;
  } plf_result_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } plf_pos_t;

  // First matching cell in cell order; row 0 column 0 when none matches.
  function automatic plf_pos_t find_pos(plf_square_t sq, logic [LETTER_W-1:0] letter);
    plf_pos_t p;
    p = '0;
    for (int r = GRID_SIZE - 1; r >= 0; r--) begin
      for (int c = GRID_SIZE - 1; c >= 0; c--) begin
        if (sq[r * GRID_SIZE + c] == letter) begin
          p.row = POS_W'(r);
          p.col = POS_W'(c);
        end
      end
    end
    return p;
  endfunction

  function automatic logic [POS_W-1:0] step_pos(logic [POS_W-1:0] v, logic dec);
    logic [POS_W-1:0] res;
    if (dec) begin
      res = (v == '0) ? POS_W'(GRID_SIZE - 1) : v - POS_W'(1);
    end else begin
      res = (v == POS_W'(GRID_SIZE - 1)) ? '0 : v + POS_W'(1);
    end
    return res;
  endfunction

endpackage

// ===== rtl/plf_pairer.sv =====
// Digraph former: J to I mapping, held letter, filler and pad insertion.
// Buffers up to two digraphs per item. Depends on plf_pkg.
module plf_pairer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [4:0]           in_letter,
  input  logic                 in_last,
  output logic                 pair_valid,
  input  logic                 pair_ready,
  output plf_pkg::plf_digraph_t pair
);
  import plf_pkg::*;

  logic [LETTER_W-1:0] held_r, held_nxt;
  logic                held_vld_r, held_vld_nxt;
  plf_digraph_t        slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic [1:0]          cnt_r, cnt_nxt;

  logic                take, accept;
  logic [LETTER_W-1:0] letter, pad, fill;
  plf_digraph_t        d0, d1;
  logic [1:0]          n;

  assign take       = pair_valid && pair_ready;
  assign pair_valid = (cnt_r != 2'd0);
  assign pair       = slot0_r;
  assign in_ready   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && take);
  assign accept     = in_valid && in_ready;

  always_comb begin
    letter       = (in_letter == LET_J) ? LET_I : in_letter;
    pad          = (letter == LET_Z) ? LET_X : LET_Z;
    fill         = (held_r == LET_X) ? LET_Q : LET_X;
    d0           = '0;
    d1           = '0;
    n            = 2'd0;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    if (held_vld_r && (held_r != letter)) begin
      d0           = '{a: held_r, b: letter, last: in_last};
      n            = 2'd1;
      held_vld_nxt = 1'b0;
    end else if (held_vld_r) begin
      d0 = '{a: held_r, b: fill, last: 1'b0};
      if (in_last) begin
        d1           = '{a: letter, b: pad, last: 1'b1};
        n            = 2'd2;
        held_vld_nxt = 1'b0;
        held_nxt     = '0;
      end else begin
        n = 2'd1;
      end
    end else if (in_last) begin
      d0       = '{a: letter, b: pad, last: 1'b1};
      n        = 2'd1;
      held_nxt = '0;
    end else begin
      held_nxt     = letter;
      held_vld_nxt = 1'b1;
    end
  end

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      slot0_nxt = d0;
      slot1_nxt = d1;
      cnt_nxt   = n;
    end else if (take) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      held_vld_r <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        held_r     <= held_nxt;
        held_vld_r <= held_vld_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

// ===== rtl/plf_lookup.sv =====
// Key square translation of one digraph: cell search, row/column rule,
// cell readback. Combinational. Depends on plf_pkg.
module plf_lookup (
  input  plf_pkg::plf_square_t  square,
  input  logic                  decrypt,
  input  plf_pkg::plf_digraph_t pair,
  output plf_pkg::plf_result_t  res
);
  import plf_pkg::*;

  plf_pos_t          pa, pb, qa, qb;
  logic [CELL_W-1:0] ia, ib;

  always_comb begin
    pa = find_pos(square, pair.a);
    pb = find_pos(square, pair.b);
    qa = pa;
    qb = pb;
    if (pa.row == pb.row) begin
      qa.col = step_pos(pa.col, decrypt);
      qb.col = step_pos(pb.col, decrypt);
    end else if (pa.col == pb.col) begin
      qa.row = step_pos(pa.row, decrypt);
      qb.row = step_pos(pb.row, decrypt);
    end else begin
      qa.col = pb.col;
      qb.col = pa.col;
    end
    ia       = CELL_W'(qa.row) * CELL_W'(GRID_SIZE) + CELL_W'(qa.col);
    ib       = CELL_W'(qb.row) * CELL_W'(GRID_SIZE) + CELL_W'(qb.col);
    res.l0   = square[ia];
    res.l1   = square[ib];
    res.last = pair.last;
  end

endmodule

// ===== rtl/plf_emitter.sv =====
// Output register: holds one translated digraph and sends its two letters
// in order. Depends on plf_pkg.
module plf_emitter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  output logic                 res_ready,
  input  plf_pkg::plf_result_t res,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [4:0]           out_letter,
  output logic                 out_last
);
  import plf_pkg::*;

  plf_result_t hold_r;
  logic        vld_r, vld_nxt;
  logic        phase_r, phase_nxt;
  logic        load;

  assign res_ready  = !vld_r || (phase_r && out_ready);
  assign load       = res_valid && res_ready;
  assign out_valid  = vld_r;
  assign out_letter = phase_r ? hold_r.l1 : hold_r.l0;
  assign out_last   = phase_r && hold_r.last;

  always_comb begin
    vld_nxt   = vld_r;
    phase_nxt = phase_r;
    if (load) begin
      vld_nxt   = 1'b1;
      phase_nxt = 1'b0;
    end else if (vld_r && out_ready) begin
      if (phase_r) begin
        vld_nxt = 1'b0;
      end else begin
        phase_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      vld_r   <= vld_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_r <= res;
    end
  end

endmodule

// ===== rtl/playfair_cipher.sv =====
// Playfair cipher top level: configuration registers, digraph former,
// key square lookup, output register. Depends on plf_pkg and submodules.
//
//   channel | direction | payload
//   in_     | slave     | tdata[4:0] letter_in, tlast last_in
//   out_    | master    | tdata[4:0] letter_out, tlast last_out
//   cfg_    | write     | index register number, data register value
//
// An item is registered in the former's buffer and its digraph then in the output
// register, from which it leaves as two letters in order; the output register
// takes the next digraph as the second letter leaves. A letter that is only held
// sends nothing. The former buffers two digraphs and takes a new item as its last
// one loads into the output register. Reset clears held letter, buffers and
// configuration; stalls back up to in_tready.
module playfair_cipher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [4:0] letter_in, [7:5] zero
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [4:0] letter_out, [7:5] zero
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [plf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [plf_pkg::HALF_W-1:0]     cfg_data
);
  import plf_pkg::*;

  logic                decrypt_r;
  logic [HALF_W-1:0]   low_r, mid_r;
  logic [LETTER_W-1:0] last_cell_r;
  plf_square_t         square;

  logic                pair_valid, pair_ready;
  plf_digraph_t        pair;
  plf_result_t         res;
  logic [LETTER_W-1:0] out_letter;

  assign cfg_ready = 1'b1;
  assign square    = {last_cell_r, mid_r, low_r};
  assign out_tdata = {3'b000, out_letter};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r   <= 1'b0;
      low_r       <= '0;
      mid_r       <= '0;
      last_cell_r <= '0;
    end else if (cfg_valid) begin
      case (plf_cfg_idx_t'(cfg_index))
        CFG_DECRYPT: decrypt_r   <= cfg_data[0];
        CFG_LOW:     low_r       <= cfg_data;
        CFG_MID:     mid_r       <= cfg_data;
        CFG_LAST:    last_cell_r <= cfg_data[LETTER_W-1:0];
        default:     decrypt_r   <= decrypt_r;
      endcase
    end
  end

  plf_pairer u_pairer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_letter  (in_tdata[LETTER_W-1:0]),
    .in_last    (in_tlast),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pair       (pair)
  );

  plf_lookup u_lookup (
    .square  (square),
    .decrypt (decrypt_r),
    .pair    (pair),
    .res     (res)
  );

  plf_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (pair_valid),
    .res_ready  (pair_ready),
    .res        (res),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_letter (out_letter),
    .out_last   (out_tlast)
  );

endmodule
